// File: rtl/core/byte_stuffed_frame_receiver_defines.svh
// Assertion macros shared by the frame receiver RTL.
`ifndef BYTE_STUFFED_FRAME_RECEIVER_DEFINES_SVH
`define BYTE_STUFFED_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BSFR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsfr same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BSFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsfr next-cycle check failed");

`endif

// File: rtl/core/bsfr_pkg.sv
// Types and constants for the byte-stuffed frame receiver.
package bsfr_pkg;

  localparam int BUF_DEPTH_DEF = 512;
  localparam int BYTE_W        = 8;
  localparam int OFF_W         = 10;
  localparam int LEN_W         = 9;
  localparam int IDX_W         = 9;
  localparam int CNT_W         = 32;
  localparam int CFG_DATA_W    = 10;
  localparam int CFG_IDX_W     = 3;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [OFF_W-1:0] OFF_MAX   = '1;
  localparam logic [OFF_W-1:0] MIN_FRAME = OFF_W'(2);
  localparam logic [LEN_W-1:0] LEN_MAX   = '1;

  localparam logic FUNC_FEED = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [BYTE_W-1:0] HEAD_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] TAIL_RST  = 8'h55;
  localparam logic [BYTE_W-1:0] ESC_RST   = 8'hA5;
  localparam logic [OFF_W-1:0]  MAXLEN_RST = OFF_W'(512);
  localparam logic [OFF_W-1:0]  SHORT_RST  = OFF_W'(17);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_HEAD       = 3'd0,
    CFG_FRAME_TAIL       = 3'd1,
    CFG_FRAME_ESCAPE     = 3'd2,
    CFG_MAX_LENGTH       = 3'd3,
    CFG_SHORT_LOSS_LIMIT = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_GOOD = 2'd0,
    KIND_BAD  = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  typedef struct packed {
    logic              func;
    logic [BYTE_W-1:0] rx_byte;
    logic [IDX_W-1:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [LEN_W-1:0]  payload_length;
    logic [BYTE_W-1:0] read_data;
    logic [CNT_W-1:0]  lost_frames;
    logic [CNT_W-1:0]  good_frames;
  } out_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] head;
    logic [BYTE_W-1:0] tail;
    logic [BYTE_W-1:0] escape;
    logic [OFF_W-1:0]  max_length;
    logic [OFF_W-1:0]  short_limit;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] rdata;
    logic              in_range;
    logic [CNT_W-1:0]  lost;
    logic [CNT_W-1:0]  good;
  } q_entry_t;

endpackage

// File: rtl/core/bsfr_front.sv
// Front end: byte classification, frame state, payload buffer and counters.
`include "byte_stuffed_frame_receiver_defines.svh"

module bsfr_front #(
  parameter int BUF_DEPTH = bsfr_pkg::BUF_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bsfr_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  bsfr_pkg::in_item_t in_data,
  output logic               q_valid,
  input  logic               q_ready,
  output bsfr_pkg::q_entry_t q_data
);
  import bsfr_pkg::*;

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int RW = IDX_W + AW;
  localparam logic [OFF_W-1:0] STORE_CAP = (BUF_DEPTH < 1023) ? OFF_W'(BUF_DEPTH) : OFF_MAX;

  logic [BYTE_W-1:0] mem [BUF_DEPTH];

  logic [BYTE_W-1:0] prev_r, prev_nxt;
  logic              in_frame_r, in_frame_nxt;
  logic              esc_r, esc_nxt;
  logic [OFF_W-1:0]  wo_r, wo_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [LEN_W-1:0]  flen_r, flen_nxt;
  logic [CNT_W-1:0]  lost_r, lost_nxt;
  logic [CNT_W-1:0]  good_r, good_nxt;
  logic [BYTE_W-1:0] m1_r, m1_nxt;
  logic [BYTE_W-1:0] m2_r, m2_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  kind_t             s1_kind_r;
  logic [LEN_W-1:0]  s1_len_r;
  logic [CNT_W-1:0]  s1_lost_r;
  logic [CNT_W-1:0]  s1_good_r;
  logic              s1_range_r;
  logic [BYTE_W-1:0] rd_r;

  logic              acc, is_read, head_pair, restart, tail_pair;
  logic              store, lost_inc, good_inc, res;
  kind_t             res_kind;
  logic [BYTE_W-1:0] d, chk;
  logic [OFF_W-1:0]  len;
  logic [OFF_W+AW-1:0] wo_ext;
  logic [RW-1:0]     ri_ext;
  logic [AW-1:0]     waddr, raddr;
  logic              in_range;

  assign acc       = in_valid && in_ready;
  assign d         = in_data.rx_byte;
  assign is_read   = (in_data.func == FUNC_READ);
  assign head_pair = (d == cfg.head) && (prev_r == cfg.head);
  assign restart   = !is_read && (head_pair || (wo_r > cfg.max_length) || (wo_r >= STORE_CAP));
  assign tail_pair = !is_read && !restart && (d == cfg.tail) && (prev_r == cfg.tail)
                     && in_frame_r;
  assign len       = wo_r - MIN_FRAME;
  assign chk       = sum_r - cfg.tail - m2_r;

  assign wo_ext   = {{AW{1'b0}}, wo_r};
  assign waddr    = wo_ext[AW-1:0];
  assign ri_ext   = {{AW{1'b0}}, in_data.read_index};
  assign raddr    = ri_ext[AW-1:0];
  assign in_range = (ri_ext < RW'(BUF_DEPTH));

  always_comb begin
    prev_nxt     = prev_r;
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    wo_nxt       = wo_r;
    sum_nxt      = sum_r;
    flen_nxt     = flen_r;
    m1_nxt       = m1_r;
    m2_nxt       = m2_r;
    store        = 1'b0;
    lost_inc     = 1'b0;
    good_inc     = 1'b0;
    res          = 1'b0;
    res_kind     = KIND_READ;
    if (acc) begin
      if (is_read) begin
        res = 1'b1;
      end else if (restart) begin
        if (in_frame_r && (wo_r != '0) && (wo_r < cfg.short_limit)) begin
          lost_inc = 1'b1;
        end
        wo_nxt       = '0;
        sum_nxt      = '0;
        esc_nxt      = 1'b0;
        in_frame_nxt = 1'b1;
        prev_nxt     = d;
      end else if (tail_pair) begin
        prev_nxt     = d;
        in_frame_nxt = 1'b0;
        esc_nxt      = 1'b0;
        sum_nxt      = '0;
        res          = 1'b1;
        if (wo_r < MIN_FRAME) begin
          flen_nxt = '0;
          lost_inc = 1'b1;
          res_kind = KIND_BAD;
        end else begin
          flen_nxt = (len > {1'b0, LEN_MAX}) ? LEN_MAX : len[LEN_W-1:0];
          if (chk == m2_r) begin
            good_inc = 1'b1;
            res_kind = KIND_GOOD;
          end else begin
            lost_inc = 1'b1;
            res_kind = KIND_BAD;
          end
        end
      end else begin
        prev_nxt = d;
        if (in_frame_r) begin
          if (esc_r) begin
            store    = 1'b1;
            esc_nxt  = 1'b0;
            prev_nxt = cfg.escape;
          end else if (d == cfg.escape) begin
            esc_nxt = 1'b1;
          end else begin
            store = 1'b1;
          end
        end
      end
    end
    if (store) begin
      wo_nxt  = wo_r + OFF_W'(1);
      sum_nxt = sum_r + d;
      m1_nxt  = d;
      m2_nxt  = m1_r;
    end
    lost_nxt = lost_r + {{(CNT_W-1){1'b0}}, lost_inc};
    good_nxt = good_r + {{(CNT_W-1){1'b0}}, good_inc};
    s1_valid_nxt = s1_valid_r && !q_ready;
    if (acc && res) begin
      s1_valid_nxt = 1'b1;
    end
  end

  assign in_ready = !s1_valid_r || q_ready;
  assign q_valid  = s1_valid_r;

  always_comb begin
    q_data.kind     = s1_kind_r;
    q_data.length   = s1_len_r;
    q_data.rdata    = rd_r;
    q_data.in_range = s1_range_r;
    q_data.lost     = s1_lost_r;
    q_data.good     = s1_good_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= '0;
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      wo_r       <= '0;
      sum_r      <= '0;
      flen_r     <= '0;
      lost_r     <= '0;
      good_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      prev_r     <= prev_nxt;
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
      wo_r       <= wo_nxt;
      sum_r      <= sum_nxt;
      flen_r     <= flen_nxt;
      lost_r     <= lost_nxt;
      good_r     <= good_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m1_r <= m1_nxt;
    m2_r <= m2_nxt;
    if (acc && res) begin
      s1_kind_r  <= res_kind;
      s1_len_r   <= flen_nxt;
      s1_lost_r  <= lost_nxt;
      s1_good_r  <= good_nxt;
      s1_range_r <= in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      mem[waddr] <= d;
    end
    if (acc && is_read) begin
      rd_r <= mem[raddr];
    end
  end

  `BSFR_ASSERT_NOW(a_offset_cap, 1'b1, wo_r <= STORE_CAP)
  `BSFR_ASSERT_NEXT(a_tail_closes, acc && tail_pair, !in_frame_r && (sum_r == '0))
  `BSFR_ASSERT_NEXT(a_read_result, acc && is_read, s1_valid_r && (s1_kind_r == KIND_READ))

endmodule

// File: rtl/core/bsfr_queue.sv
// Short FIFO between the front end and the result stage.
`include "byte_stuffed_frame_receiver_defines.svh"

module bsfr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  bsfr_pkg::q_entry_t push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output bsfr_pkg::q_entry_t pop_data
);
  import bsfr_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

  q_entry_t        slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt;
  logic [PW-1:0]   rp_r, rp_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            push, pop;

  assign push_ready = (count_r != FULL);
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slot_r[rp_r];

  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    count_nxt = count_r;
    if (push) begin
      wp_nxt = (wp_r == LAST) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == LAST) ? '0 : rp_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

  `BSFR_ASSERT_NOW(a_count_bound, 1'b1, count_r <= FULL)
  `BSFR_ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + CW'(1))
  `BSFR_ASSERT_NEXT(a_count_down, pop && !push, count_r == $past(count_r) - CW'(1))

endmodule

// File: rtl/core/bsfr_back.sv
// Result stage: formats queued results into the output register.
module bsfr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  bsfr_pkg::q_entry_t  pop_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bsfr_pkg::out_item_t out_data
);
  import bsfr_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      load;

  assign pop_ready = !out_valid_r || out_ready;
  assign load      = pop_valid && pop_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (load) begin
      out_valid_nxt = 1'b1;
    end
    out_data_nxt.kind           = pop_data.kind;
    out_data_nxt.payload_length = pop_data.length;
    out_data_nxt.read_data      = ((pop_data.kind == KIND_READ) && pop_data.in_range)
                                  ? pop_data.rdata : '0;
    out_data_nxt.lost_frames    = pop_data.lost;
    out_data_nxt.good_frames    = pop_data.good;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// File: rtl/core/byte_stuffed_frame_receiver.sv
// Byte-stuffed frame receiver top level: configuration registers and pipeline.
// Takes one transaction per clock, byte or buffer read, sustained; in_ready only
// drops when the two-entry result queue and the front result stage are both full
// because out_ready is held low. A result goes from the front result stage through the
// result queue to the output register on out_*. Received payload goes into a BUF_DEPTH
// x 8 buffer with one write and one registered read port; the checksum byte is tracked
// in registers, so a frame result never waits on the buffer. The buffer has no reset
// and needs no clearing pass: reading an entry never written returns junk.
module byte_stuffed_frame_receiver #(
  parameter int BUF_DEPTH = bsfr_pkg::BUF_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bsfr_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bsfr_pkg::out_item_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [bsfr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bsfr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bsfr_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  logic     q_push_valid, q_push_ready;
  q_entry_t q_push_data;
  logic     q_pop_valid, q_pop_ready;
  q_entry_t q_pop_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FRAME_HEAD:       cfg_nxt.head        = cfg_data[BYTE_W-1:0];
        CFG_FRAME_TAIL:       cfg_nxt.tail        = cfg_data[BYTE_W-1:0];
        CFG_FRAME_ESCAPE:     cfg_nxt.escape      = cfg_data[BYTE_W-1:0];
        CFG_MAX_LENGTH:       cfg_nxt.max_length  = cfg_data[OFF_W-1:0];
        CFG_SHORT_LOSS_LIMIT: cfg_nxt.short_limit = cfg_data[OFF_W-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.head        <= HEAD_RST;
      cfg_r.tail        <= TAIL_RST;
      cfg_r.escape      <= ESC_RST;
      cfg_r.max_length  <= MAXLEN_RST;
      cfg_r.short_limit <= SHORT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bsfr_front #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_push_valid),
    .q_ready  (q_push_ready),
    .q_data   (q_push_data)
  );

  bsfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  bsfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_data  (q_pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: verif/byte_stuffed_frame_receiver_checker.sv
// Checker for the frame receiver: tracks the block's state, predicts each result and compares.
module byte_stuffed_frame_receiver_checker #(
  parameter int BUF_DEPTH = bsfr_pkg::BUF_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  bsfr_pkg::in_item_t                  in_data,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  bsfr_pkg::out_item_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [bsfr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bsfr_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                  fail_count,
  output int                                  pending,
  output logic [BUF_DEPTH-1:0]                stored_map
);
  timeunit 1ns;
  timeprecision 1ps;
  import bsfr_pkg::*;

  localparam int STORE_CAP = (BUF_DEPTH < 1023) ? BUF_DEPTH : 1023;

  logic [BYTE_W-1:0] head_r, tail_r, esc_r;
  logic [OFF_W-1:0]  max_len_r, short_lim_r;
  logic [BYTE_W-1:0] last_byte;
  logic              frame_open, esc_armed;
  logic [OFF_W-1:0]  fill;
  logic [BYTE_W-1:0] byte_sum;
  logic [BYTE_W-1:0] payload_mem [BUF_DEPTH];
  logic [BUF_DEPTH-1:0] mem_valid;
  logic [LEN_W-1:0]  last_len;
  logic [CNT_W-1:0]  lost_cnt, good_cnt;
  out_item_t         expected_reports [$];
  int                errors = 0;

  task automatic keep_byte(input logic [BYTE_W-1:0] b);
    if (fill < BUF_DEPTH) begin
      payload_mem[fill] = b;
      mem_valid[fill] = 1'b1;
    end
    fill = fill + 1'b1;
    byte_sum = byte_sum + b;
  endtask

  task automatic queue_report(input kind_t k, input logic [LEN_W-1:0] len,
                              input logic [BYTE_W-1:0] data);
    out_item_t r;
    r.kind = k;
    r.payload_length = len;
    r.read_data = data;
    r.lost_frames = lost_cnt;
    r.good_frames = good_cnt;
    expected_reports.push_back(r);
  endtask

  task automatic track_transaction(input in_item_t it);
    logic [BYTE_W-1:0] b, cs, resid;
    logic [OFF_W-1:0]  plen;
    kind_t             k;
    b = it.rx_byte;
    if (it.func == FUNC_READ) begin
      if (it.read_index < BUF_DEPTH) begin
        queue_report(KIND_READ, last_len, payload_mem[it.read_index]);
      end else begin
        queue_report(KIND_READ, last_len, '0);
      end
    end else if ((b == head_r && last_byte == head_r) || fill > max_len_r ||
                 fill >= STORE_CAP) begin
      if (frame_open && fill > 0 && fill < short_lim_r) lost_cnt = lost_cnt + 1'b1;
      fill = '0;
      byte_sum = '0;
      esc_armed = 1'b0;
      frame_open = 1'b1;
      last_byte = b;
    end else if (b == tail_r && last_byte == tail_r && frame_open) begin
      last_byte = b;
      frame_open = 1'b0;
      esc_armed = 1'b0;
      if (fill < MIN_FRAME) begin
        last_len = '0;
        lost_cnt = lost_cnt + 1'b1;
        k = KIND_BAD;
      end else begin
        // first tail byte was stored; strip it and the checksum from the sum
        plen = fill - MIN_FRAME;
        cs = (plen < BUF_DEPTH) ? payload_mem[plen] : '0;
        resid = byte_sum - tail_r - cs;
        last_len = (plen > LEN_MAX) ? LEN_MAX : plen[LEN_W-1:0];
        if (resid == cs) begin
          good_cnt = good_cnt + 1'b1;
          k = KIND_GOOD;
        end else begin
          lost_cnt = lost_cnt + 1'b1;
          k = KIND_BAD;
        end
      end
      byte_sum = '0;
      queue_report(k, last_len, '0);
    end else begin
      last_byte = b;
      if (frame_open) begin
        if (esc_armed) begin
          keep_byte(b);
          esc_armed = 1'b0;
          last_byte = esc_r;
        end else if (b == esc_r) begin
          esc_armed = 1'b1;
        end else begin
          keep_byte(b);
        end
      end
    end
  endtask

  task automatic compare_field(input string what, input logic [CNT_W-1:0] e,
                               input logic [CNT_W-1:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, what, e, a);
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      head_r = HEAD_RST;
      tail_r = TAIL_RST;
      esc_r = ESC_RST;
      max_len_r = MAXLEN_RST;
      short_lim_r = SHORT_RST;
      last_byte = '0;
      frame_open = 1'b0;
      esc_armed = 1'b0;
      fill = '0;
      byte_sum = '0;
      last_len = '0;
      lost_cnt = '0;
      good_cnt = '0;
      mem_valid = '0;
      expected_reports.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FRAME_HEAD:       head_r = cfg_data[BYTE_W-1:0];
          CFG_FRAME_TAIL:       tail_r = cfg_data[BYTE_W-1:0];
          CFG_FRAME_ESCAPE:     esc_r = cfg_data[BYTE_W-1:0];
          CFG_MAX_LENGTH:       max_len_r = cfg_data[OFF_W-1:0];
          CFG_SHORT_LOSS_LIMIT: short_lim_r = cfg_data[OFF_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) track_transaction(in_data);
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, actual %h", $time, out_data);
        end else begin
          want = expected_reports.pop_front();
          compare_field("kind", want.kind, out_data.kind);
          compare_field("payload_length", want.payload_length, out_data.payload_length);
          compare_field("read_data", want.read_data, out_data.read_data);
          compare_field("lost_frames", want.lost_frames, out_data.lost_frames);
          compare_field("good_frames", want.good_frames, out_data.good_frames);
        end
      end
    end
    pending <= expected_reports.size();
    stored_map <= mem_valid;
    fail_count <= errors;
  end

endmodule

// File: verif/byte_stuffed_frame_receiver_tb.sv
// Testbench top for the frame receiver: clock, reset, stimulus phases and the verdict.
module byte_stuffed_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bsfr_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int                     fail_count;
  int                     pending;
  logic [BUF_DEPTH_DEF-1:0] stored_map;

  int                     in_idle_pct = 0;
  int                     out_stall_pct = 0;
  int                     holds_asked = 0;
  int                     holds_done = 0;
  logic [BYTE_W-1:0]      cur_head = HEAD_RST;
  logic [BYTE_W-1:0]      cur_tail = TAIL_RST;
  logic [BYTE_W-1:0]      cur_esc = ESC_RST;
  in_item_t               burst [$];

  always #5 clk = ~clk;

  byte_stuffed_frame_receiver DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  byte_stuffed_frame_receiver_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .stored_map (stored_map)
  );

  // result side; a requested hold-off keeps out_ready low for a long stretch
  always begin
    @(negedge clk);
    if (holds_asked != holds_done) begin
      holds_done++;
      repeat (60) begin
        out_ready <= 1'b0;
        @(negedge clk);
      end
    end
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic load_cfg(input logic [BYTE_W-1:0] h, input logic [BYTE_W-1:0] t,
                          input logic [BYTE_W-1:0] e, input logic [OFF_W-1:0] ml,
                          input logic [OFF_W-1:0] sl);
    cfg_write(CFG_FRAME_HEAD, CFG_DATA_W'(h));
    cfg_write(CFG_FRAME_TAIL, CFG_DATA_W'(t));
    cfg_write(CFG_FRAME_ESCAPE, CFG_DATA_W'(e));
    cfg_write(CFG_MAX_LENGTH, CFG_DATA_W'(ml));
    cfg_write(CFG_SHORT_LOSS_LIMIT, CFG_DATA_W'(sl));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_head = h;
    cur_tail = t;
    cur_esc = e;
  endtask

  task automatic send_one(input in_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct && gap < 40) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic flush_burst();
    while (burst.size() > 0) send_one(burst.pop_front());
  endtask

  task automatic add_byte(input logic [BYTE_W-1:0] b);
    in_item_t it;
    it.func = FUNC_FEED;
    it.rx_byte = b;
    it.read_index = IDX_W'($urandom_range(511));
    burst.push_back(it);
  endtask

  task automatic add_read(input int idx);
    in_item_t it;
    it.func = FUNC_READ;
    it.rx_byte = BYTE_W'($urandom);
    it.read_index = IDX_W'(idx);
    burst.push_back(it);
  endtask

  task automatic add_lit(input logic [BYTE_W-1:0] b);
    if (b == cur_head || b == cur_tail || b == cur_esc) add_byte(cur_esc);
    add_byte(b);
  endtask

  function automatic logic [BYTE_W-1:0] rand_byte();
    case ($urandom_range(9))
      0:       return cur_head;
      1:       return cur_tail;
      2:       return cur_esc;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  task automatic add_frame(input int n, input bit corrupt, input bit plain);
    logic [BYTE_W-1:0] b, sum;
    sum = '0;
    add_byte(cur_head);
    add_byte(cur_head);
    for (int i = 0; i < n; i++) begin
      b = plain ? BYTE_W'($urandom) : rand_byte();
      add_lit(b);
      sum = sum + b;
    end
    if (corrupt) sum = sum + BYTE_W'($urandom_range(1, 255));
    add_lit(sum);
    add_byte(cur_tail);
    add_byte(cur_tail);
  endtask

  // only entries already written may be read back
  function automatic int pick_index();
    int i;
    for (int k = 0; k < 24; k++) begin
      i = $urandom_range(BUF_DEPTH_DEF - 1);
      if (stored_map[i]) return i;
    end
    for (int j = 0; j < BUF_DEPTH_DEF; j++) begin
      if (stored_map[j]) return j;
    end
    return -1;
  endfunction

  task automatic run_traffic(input int n);
    int done, pick, idx, cnt;
    bit counted;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(99);
      counted = 1'b1;
      if (pick < 55) begin
        cnt = ($urandom_range(9) == 0) ? $urandom_range(11, 60) : $urandom_range(0, 10);
        add_frame(cnt, $urandom_range(9) == 0, 1'b0);
      end else if (pick < 67) begin
        cnt = $urandom_range(1, 3);
        for (int i = 0; i < cnt; i++) begin
          idx = pick_index();
          if (idx >= 0) add_read(idx);
        end
      end else if (pick < 75) begin
        counted = 1'b0;
        cnt = $urandom_range(1, 4);
        for (int i = 0; i < cnt; i++) add_byte(BYTE_W'($urandom));
      end else if (pick < 84) begin
        add_byte(cur_head);
        add_byte(cur_head);
        cnt = $urandom_range(0, 24);
        for (int i = 0; i < cnt; i++) add_lit(BYTE_W'($urandom));
      end else if (pick < 92) begin
        add_byte(cur_head);
        add_byte(cur_head);
        if ($urandom_range(1)) add_byte(BYTE_W'($urandom));
        add_byte(cur_tail);
        add_byte(cur_tail);
      end else begin
        if ($urandom_range(1)) begin
          add_byte(cur_head);
          add_byte(cur_head);
        end
        cnt = $urandom_range(3, 12);
        for (int i = 0; i < cnt; i++) add_byte(rand_byte());
      end
      if (counted) done += burst.size();
      flush_burst();
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: stray bytes, empty frame, escaped specials, read-back, aborted short frame
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(cur_head);
    add_byte(cur_head);
    add_byte(cur_tail);
    add_byte(cur_tail);
    add_byte(cur_head);
    add_byte(cur_head);
    add_lit(8'hAA);
    add_lit(8'h55);
    add_lit(8'hA5);
    add_lit(8'hA4);
    add_byte(cur_tail);
    add_byte(cur_tail);
    add_read(0);
    add_read(2);
    add_byte(cur_head);
    add_byte(cur_head);
    add_byte(8'h07);
    add_byte(cur_head);
    add_byte(cur_head);
    flush_burst();
    settle();

    load_cfg(HEAD_RST, TAIL_RST, ESC_RST, MAXLEN_RST, SHORT_RST);
    run_traffic(80);
    settle();

    load_cfg(8'h00, 8'hFF, 8'h80, OFF_W'(2), OFF_W'(0));
    in_idle_pct = 78;
    run_traffic(60);
    settle();

    load_cfg(8'hFF, 8'h00, 8'h7F, OFF_W'(40), OFF_W'(512));
    in_idle_pct = 0;
    out_stall_pct = 78;
    run_traffic(80);
    settle();

    // frame that runs into the storage cap, then read-back under a long hold-off
    load_cfg(8'h7E, 8'h7D, 8'h7C, OFF_W'(512), OFF_W'(1));
    out_stall_pct = 0;
    add_frame(510, 1'b0, 1'b1);
    flush_burst();
    holds_asked++;
    add_read(0);
    add_read(BUF_DEPTH_DEF - 1);
    for (int i = 0; i < 38; i++) add_read(pick_index());
    flush_burst();
    settle();

    load_cfg(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
             OFF_W'($urandom_range(2, 80)), OFF_W'($urandom_range(0, 512)));
    in_idle_pct = 27;
    out_stall_pct = 27;
    run_traffic(70);
    settle();

    load_cfg(HEAD_RST, TAIL_RST, ESC_RST, MAXLEN_RST, SHORT_RST);
    run_traffic(70);
    settle();
    repeat (20) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
